@@ src/rks_pkg.sv @@
// Shared constants for the range k-th smallest block: field widths, codes, defaults.
package rks_pkg;

	localparam int RKS_POSITIONS  = 1024;
	localparam int RKS_VALUE_BITS = 16;

	localparam int POS_W    = 11;
	localparam int VAL_W    = 16;
	localparam int STATUS_W = 2;

	localparam logic CMD_SET   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_RANK  = 2'd2;

endpackage

@@ src/rks_store.sv @@
// Position store: one value and one valid mark per position, with a clearing pass after reset.
module rks_store import rks_pkg::*; #(
	parameter int POSITIONS  = RKS_POSITIONS,
	parameter int VALUE_BITS = RKS_VALUE_BITS,
	localparam int AW = (POSITIONS > 1) ? $clog2(POSITIONS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  logic [VALUE_BITS-1:0] wr_data,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output logic                  rd_mark,
	output logic [VALUE_BITS-1:0] rd_value,
	output logic                  clear_busy
);

	// word layout: {valid mark, value}
	logic [VALUE_BITS:0] mem [0:POSITIONS-1];
	logic [VALUE_BITS:0] rdata_q;
	logic [AW-1:0]       clr_addr_q;
	logic                clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(POSITIONS - 1))
				clearing_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q)
			mem[clr_addr_q] <= '0;
		else if (wr_en)
			mem[wr_addr] <= {1'b1, wr_data};
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	assign rd_mark    = rdata_q[VALUE_BITS];
	assign rd_value   = rdata_q[VALUE_BITS-1:0];
	assign clear_busy = clearing_q;

endmodule

@@ src/range_kth_smallest_with_updates_top.sv @@
// Top level of the range k-th smallest block: handshakes, sequencer and shared counting unit.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------------------
//   input    | in_valid / in_stall       | cmd, position, new_value, range_left,
//            |                           | range_right, rank
//   output   | out_valid / out_stall     | kth_value, status
//   config   | cfg_write_en              | cfg_write_data (active_positions)
//
// A set request, or a query with a bad range, goes straight to the result.
// A query over L = range_right - range_left + 1 positions makes one counting pass
// and then, unless the rank is bad, one pass per value bit, each reading the store
// one position a cycle through its single read port.
// After reset the store is cleared one position a cycle with in_stall held high;
// configuration writes are taken at any time.
// A new request is taken while a finished result still waits in the output register.
module range_kth_smallest_with_updates_top import rks_pkg::*; #(
	parameter int POSITIONS  = RKS_POSITIONS,
	parameter int VALUE_BITS = RKS_VALUE_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_write_en,
	input  logic [POS_W-1:0]    cfg_write_data,
	// requests
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                cmd,
	input  logic [POS_W-1:0]    position,
	input  logic [VAL_W-1:0]    new_value,
	input  logic [POS_W-1:0]    range_left,
	input  logic [POS_W-1:0]    range_right,
	input  logic [POS_W-1:0]    rank,
	// results
	output logic                out_valid,
	input  logic                out_stall,
	output logic [VAL_W-1:0]    kth_value,
	output logic [STATUS_W-1:0] status
);

	localparam int AW = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
	localparam int ACTIVE_RESET = (POSITIONS < 1024) ? POSITIONS : 1024;

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_STEP   = 3'd2;
	localparam logic [2:0] S_FINISH = 3'd3;

	logic [2:0]            state_q;
	logic [POS_W-1:0]      active_q;

	// request registers
	logic [POS_W-1:0]      lo_q;
	logic [POS_W-1:0]      hi_q;
	logic [POS_W-1:0]      k_q;

	// scan pipeline
	logic [POS_W-1:0]      idx_q;
	logic                  issue_q;
	logic                  rd_v_s1;
	logic                  last_s1;
	logic [POS_W-1:0]      acc_q;
	logic                  count_pass_q;
	logic [VALUE_BITS-1:0] bit_q;
	logic [VALUE_BITS-1:0] upper_q;
	logic [VALUE_BITS-1:0] prefix_q;

	// result
	logic [VALUE_BITS-1:0] res_value_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic                  out_valid_q;
	logic [VAL_W-1:0]      kth_q;
	logic [STATUS_W-1:0]   status_q;

	// store interface
	logic                  clear_busy;
	logic                  rd_mark;
	logic [VALUE_BITS-1:0] rd_value;
	logic                  wr_en;
	logic                  rd_en;
	logic                  accept;
	logic                  pos_ok;
	logic                  range_ok;
	logic                  hit;
	logic                  out_load;
	logic                  take_one;
	logic [POS_W-1:0]      cfg_clamped;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || clear_busy;

	assign pos_ok   = (position != '0) && (position <= active_q);
	assign range_ok = (range_left != '0) && (range_right <= active_q)
		&& (range_left <= range_right);

	assign wr_en = accept && (cmd == CMD_SET) && pos_ok;
	assign rd_en = (state_q == S_SCAN) && issue_q;

	// clamp the register write into 1..POSITIONS
	always_comb begin
		cfg_clamped = cfg_write_data;
		if (cfg_write_data == '0)
			cfg_clamped = POS_W'(1);
		else if (32'(cfg_write_data) > POSITIONS)
			cfg_clamped = POS_W'(POSITIONS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			active_q <= POS_W'(ACTIVE_RESET);
		else if (cfg_write_en)
			active_q <= cfg_clamped;
	end

	rks_store #(
		.POSITIONS  (POSITIONS),
		.VALUE_BITS (VALUE_BITS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_addr    (AW'(position - POS_W'(1))),
		.wr_data    (VALUE_BITS'(new_value)),
		.rd_en      (rd_en),
		.rd_addr    (AW'(idx_q - POS_W'(1))),
		.rd_mark    (rd_mark),
		.rd_value   (rd_value),
		.clear_busy (clear_busy)
	);

	// shared compare unit: does the word just read match this pass?
	always_comb begin
		if (count_pass_q)
			hit = rd_mark;
		else
			hit = rd_mark && ((rd_value & upper_q) == prefix_q)
				&& ((rd_value & bit_q) == '0);
	end

	assign take_one = k_q > acc_q;
	assign out_load = (state_q == S_FINISH) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			issue_q <= 1'b0;
			rd_v_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
			last_s1 <= rd_en && (idx_q == hi_q);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd == CMD_QUERY && range_ok) begin
							state_q <= S_SCAN;
							issue_q <= 1'b1;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_SCAN: begin
					// stop issuing after the last position of the range
					if (rd_en && idx_q == hi_q)
						issue_q <= 1'b0;
					if (rd_v_s1 && last_s1)
						state_q <= S_STEP;
				end
				S_STEP: begin
					if (count_pass_q) begin
						if (k_q == '0 || take_one) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_SCAN;
							issue_q <= 1'b1;
						end
					end else if (bit_q[0]) begin
						state_q <= S_FINISH;
					end else begin
						state_q <= S_SCAN;
						issue_q <= 1'b1;
					end
				end
				S_FINISH: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					lo_q         <= range_left;
					hi_q         <= range_right;
					k_q          <= rank;
					idx_q        <= range_left;
					acc_q        <= '0;
					count_pass_q <= 1'b1;
					bit_q        <= {1'b1, {(VALUE_BITS-1){1'b0}}};
					upper_q      <= '0;
					prefix_q     <= '0;
					res_value_q  <= '0;
					if (cmd == CMD_SET)
						res_status_q <= pos_ok ? ST_OK : ST_BAD_RANGE;
					else
						res_status_q <= range_ok ? ST_OK : ST_BAD_RANGE;
				end
			end
			S_SCAN: begin
				if (rd_en)
					idx_q <= idx_q + POS_W'(1);
				if (rd_v_s1 && hit)
					acc_q <= acc_q + POS_W'(1);
			end
			S_STEP: begin
				// restart the scan for the next pass
				idx_q <= lo_q;
				acc_q <= '0;
				if (count_pass_q) begin
					count_pass_q <= 1'b0;
					if (k_q == '0 || take_one)
						res_status_q <= ST_BAD_RANK;
				end else begin
					// fix this bit: 1 when the rank lies beyond the zeros
					if (take_one) begin
						k_q      <= k_q - acc_q;
						prefix_q <= prefix_q | bit_q;
					end
					if (bit_q[0])
						res_value_q <= take_one ? (prefix_q | bit_q) : prefix_q;
					bit_q   <= bit_q >> 1;
					upper_q <= upper_q | bit_q;
				end
			end
			default: begin
			end
		endcase
	end

	// output register: holds the result until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kth_q    <= VAL_W'(res_value_q);
			status_q <= res_status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign kth_value = kth_q;
	assign status    = status_q;

endmodule
